### sv/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the request frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned FRAME_LEN_W = 13;
  localparam int unsigned ARG_CNT_W   = 11;
  localparam int unsigned ARG_IDX_W   = 10;
  localparam int unsigned HDR_BYTES   = 4;

  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 13'd4096;
  localparam logic [ARG_CNT_W-1:0]   MAX_ARG_CNT_RST   = 11'd1024;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY_ARG = 2'd1,
    KIND_NO_ARGS   = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TOO_LONG      = 3'd1,
    ERR_SHORT         = 3'd2,
    ERR_TOO_MANY_ARGS = 3'd3,
    ERR_OVERRUN       = 3'd4,
    ERR_TRAILING      = 3'd5
  } err_t;

  typedef enum logic {
    REG_MAX_FRAME_LEN = 1'b0,
    REG_MAX_ARG_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] max_frame_len;
    logic [ARG_CNT_W-1:0]   max_arg_count;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           payload;
    logic [ARG_IDX_W-1:0] arg_number;
    logic                 arg_end;
    logic                 request_end;
    err_t                 error_code;
  } res_t;

endpackage

### sv/rfd_if.sv
// ----------------------------------------------------------------------------
// rfd_in_if / rfd_out_if
// Valid/ready channels carrying stream bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface rfd_in_if import rfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rfd_out_if import rfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           payload;
  logic [ARG_IDX_W-1:0] arg_number;
  logic                 arg_end;
  logic                 request_end;
  logic [2:0]           error_code;

  modport source (output valid, output kind, output payload, output arg_number,
                  output arg_end, output request_end, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input payload, input arg_number,
                  input arg_end, input request_end, input error_code,
                  output ready);
endinterface

### sv/request_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// request_frame_deframer_top
// Splits a length-prefixed request byte stream into tagged argument bytes.
// ----------------------------------------------------------------------------
// Path: a byte accepted on in_s waits in the input register, then passes
//   through the parser into the result register; a full result register
//   that out_m does not drain holds it in the input register.
// Throughput: one byte per cycle unless out_m stalls, set by the single-pass parse stage.
// Reset: synchronous on rst_n; clears both pipeline valids and all parser state,
//   and loads the limit registers with 4096 / 1024. A frame error is sticky until reset.
// ----------------------------------------------------------------------------
module request_frame_deframer_top import rfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 4096,
  parameter int unsigned MAX_ARGS        = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rfd_in_if.sink      in_s,
  rfd_out_if.source   out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Input register: holds one accepted byte until the parser takes it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Result register: decouples the consumer from the parser.
  logic       out_valid_r;
  res_t       out_res_r;

  cfg_t       cfg;
  logic       consume;
  logic       res_valid;
  res_t       res;

  // The parser advances whenever the result register can take a new value,
  // whether or not this byte produces a result.
  assign consume    = s1_valid_r && (!out_valid_r || out_m.ready);
  assign in_s.ready = !s1_valid_r || consume;

  rfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfd_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_ARGS        (MAX_ARGS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume),
    .in_byte   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.valid && in_s.ready) begin
      s1_valid_r <= 1'b1;
    end else if (consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      s1_byte_r <= in_s.data_byte;
    end
  end

  // result stage control: a consumed byte without a result empties the slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume) begin
      out_valid_r <= res_valid;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_m.valid       = out_valid_r;
  assign out_m.kind        = out_res_r.kind;
  assign out_m.payload     = out_res_r.payload;
  assign out_m.arg_number  = out_res_r.arg_number;
  assign out_m.arg_end     = out_res_r.arg_end;
  assign out_m.request_end = out_res_r.request_end;
  assign out_m.error_code  = out_res_r.error_code;

  a_err_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.kind == KIND_ERROR) == (out_res_r.error_code != ERR_NONE)))
    else $error("error code and result kind disagree");

  a_no_args_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == KIND_NO_ARGS
      |-> out_res_r.request_end && out_res_r.arg_number == '0 && !out_res_r.arg_end)
    else $error("empty request marker malformed");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !consume |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a byte the parser had not taken");

endmodule

### sv/rfd_cfg.sv
// ----------------------------------------------------------------------------
// rfd_cfg
// APB-style register file holding the frame length and argument count limits.
// ----------------------------------------------------------------------------
module rfd_cfg import rfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_FRAME_LEN: cfg_nxt.max_frame_len = pwdata[FRAME_LEN_W-1:0];
        REG_MAX_ARG_COUNT: cfg_nxt.max_arg_count = pwdata[ARG_CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_FRAME_LEN: prdata = {{(32-FRAME_LEN_W){1'b0}}, cfg_r.max_frame_len};
      REG_MAX_ARG_COUNT: prdata = {{(32-ARG_CNT_W){1'b0}}, cfg_r.max_arg_count};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len <= MAX_FRAME_LEN_RST;
      cfg_r.max_arg_count <= MAX_ARG_CNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/rfd_parse.sv
// ----------------------------------------------------------------------------
// rfd_parse
// Frame parser: header assembly, frame/argument counters, result decode.
// ----------------------------------------------------------------------------
module rfd_parse import rfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 4096,
  parameter int unsigned MAX_ARGS        = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [16:0] FRAME_CAP = 17'(MAX_FRAME_BYTES);
  localparam logic [16:0] ARG_CAP   = 17'(MAX_ARGS);

  typedef enum logic [4:0] {
    PH_LEN     = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_ARGLEN  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [23:0]            hdr_r, hdr_nxt;
  logic [1:0]             hcnt_r, hcnt_nxt;
  logic [FRAME_LEN_W-1:0] flen_r, flen_nxt;
  logic [FRAME_LEN_W-1:0] fpos_r, fpos_nxt;
  logic [ARG_CNT_W-1:0]   args_r, args_nxt;
  logic [FRAME_LEN_W-1:0] abytes_r, abytes_nxt;
  logic [ARG_IDX_W-1:0]   cur_r, cur_nxt;

  logic [16:0]            flimit;
  logic [16:0]            alimit;
  logic [31:0]            hdr_word;
  logic                   hdr_done;
  logic [FRAME_LEN_W-1:0] pos_inc;
  logic [FRAME_LEN_W-1:0] room;
  logic                   fin;
  err_t                   err;

  // effective limits: smaller of register and build-time cap
  assign flimit = ({4'b0, cfg.max_frame_len} < FRAME_CAP) ?
                  {4'b0, cfg.max_frame_len} : FRAME_CAP;
  assign alimit = ({6'b0, cfg.max_arg_count} < ARG_CAP) ?
                  {6'b0, cfg.max_arg_count} : ARG_CAP;

  // little-endian field: the completing byte is the most significant
  assign hdr_word = {in_byte, hdr_r};
  assign hdr_done = (hcnt_r == 2'd3);
  assign pos_inc  = fpos_r + 1'b1;
  assign room     = flen_r - pos_inc;

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    hcnt_nxt   = hcnt_r;
    flen_nxt   = flen_r;
    fpos_nxt   = fpos_r;
    args_nxt   = args_r;
    abytes_nxt = abytes_r;
    cur_nxt    = cur_r;
    fin        = 1'b0;
    err        = ERR_NONE;
    res_valid  = 1'b0;
    res        = '{kind: KIND_PAYLOAD, payload: 8'd0, arg_number: cur_r,
                   arg_end: 1'b0, request_end: 1'b0, error_code: ERR_NONE};

    unique case (phase_r)
      PH_LEN: begin
        hdr_nxt  = hdr_word[31:8];
        hcnt_nxt = hcnt_r + 1'b1;
        if (hdr_done) begin
          if (hdr_word > {15'b0, flimit}) begin
            err = ERR_TOO_LONG;
          end else if (hdr_word < 32'(HDR_BYTES)) begin
            err = ERR_SHORT;
          end else begin
            flen_nxt  = hdr_word[FRAME_LEN_W-1:0];
            fpos_nxt  = '0;
            phase_nxt = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        fpos_nxt = pos_inc;
        hdr_nxt  = hdr_word[31:8];
        hcnt_nxt = hcnt_r + 1'b1;
        if (hdr_done) begin
          cur_nxt = '0;
          if (hdr_word > {15'b0, alimit}) begin
            err = ERR_TOO_MANY_ARGS;
          end else begin
            args_nxt = hdr_word[ARG_CNT_W-1:0];
            if (hdr_word == 32'd0) begin
              if (pos_inc != flen_r) begin
                err = ERR_TRAILING;
              end else begin
                res_valid       = 1'b1;
                res.kind        = KIND_NO_ARGS;
                res.arg_number  = '0;
                res.request_end = 1'b1;
                phase_nxt       = PH_LEN;
              end
            end else if (room < FRAME_LEN_W'(HDR_BYTES)) begin
              err = ERR_OVERRUN;
            end else begin
              phase_nxt = PH_ARGLEN;
            end
          end
        end
      end
      PH_ARGLEN: begin
        fpos_nxt = pos_inc;
        hdr_nxt  = hdr_word[31:8];
        hcnt_nxt = hcnt_r + 1'b1;
        if (hdr_done) begin
          if (hdr_word > {19'b0, room}) begin
            err = ERR_OVERRUN;
          end else if (hdr_word == 32'd0) begin
            res_valid   = 1'b1;
            res.kind    = KIND_EMPTY_ARG;
            res.arg_end = 1'b1;
            fin         = 1'b1;
          end else begin
            abytes_nxt = hdr_word[FRAME_LEN_W-1:0];
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        fpos_nxt    = pos_inc;
        abytes_nxt  = abytes_r - 1'b1;
        res_valid   = 1'b1;
        res.payload = in_byte;
        if (abytes_r == FRAME_LEN_W'(1)) begin
          res.arg_end = 1'b1;
          fin         = 1'b1;
        end
      end
      PH_ERROR: begin
        // sticky: bytes are swallowed until reset
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    // end of an argument: next argument, end of request, or a late error
    if (fin) begin
      args_nxt = args_r - 1'b1;
      if (args_r == ARG_CNT_W'(1)) begin
        if (pos_inc == flen_r) begin
          res.request_end = 1'b1;
          phase_nxt       = PH_LEN;
        end else begin
          err = ERR_TRAILING;
        end
      end else begin
        cur_nxt = cur_r + 1'b1;
        if (room < FRAME_LEN_W'(HDR_BYTES)) begin
          err = ERR_OVERRUN;
        end else begin
          phase_nxt = PH_ARGLEN;
        end
      end
    end

    // an error replaces whatever result the byte would have given
    if (err != ERR_NONE) begin
      phase_nxt = PH_ERROR;
      res_valid = 1'b1;
      res       = '{kind: KIND_ERROR, payload: 8'd0, arg_number: cur_nxt,
                    arg_end: 1'b0, request_end: 1'b0, error_code: err};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      hdr_r    <= '0;
      hcnt_r   <= '0;
      flen_r   <= '0;
      fpos_r   <= '0;
      args_r   <= '0;
      abytes_r <= '0;
      cur_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      hcnt_r   <= hcnt_nxt;
      flen_r   <= flen_nxt;
      fpos_r   <= fpos_nxt;
      args_r   <= args_nxt;
      abytes_r <= abytes_nxt;
      cur_r    <= cur_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("parser left the error state before reset");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COUNT || phase_r == PH_ARGLEN || phase_r == PH_PAYLOAD)
      |-> fpos_r <= flen_r)
    else $error("frame position ran past the frame length");

  a_payload_state: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> abytes_r != '0 && hcnt_r == 2'd0 && args_r != '0)
    else $error("payload phase entered with inconsistent counters");

endmodule

### tb/tb_request_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_frame_deframer_top
// Self-checking bench for the request frame deframer. Byte transactions go
// in through a valid/ready channel and are run through a local deframing
// model as they are accepted. Every result transaction is compared field by
// field with the oldest predicted one. The limit registers are written
// over APB between phases and read back. Stall mixes vary from phase to
// phase, and one long receiver hold-off fills the pipeline. The run closes
// with one malformed frame, since an error is sticky until reset.
// ----------------------------------------------------------------------------
module tb_request_frame_deframer_top;
  import rfd_pkg::*;

  localparam int unsigned FRAME_CAP        = 4096;  // MAX_FRAME_BYTES of the instance
  localparam int unsigned ARGS_CAP         = 1024;  // MAX_ARGS of the instance
  localparam int unsigned RESET_CYCLES     = 9;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD        = 200;
  localparam int unsigned PHASE_BYTES      = 40;    // least number of bytes offered per stall mix
  localparam int unsigned NOISE_BYTES      = 40;
  localparam int unsigned MAX_RANDOM_ARGS  = 6;
  localparam int unsigned MAX_RANDOM_SIZE  = 16;
  localparam longint      TIMEOUT_NS       = 2_000_000;

  // Local parser phases
  typedef enum logic [2:0] {
    PH_FRAME_LEN,
    PH_ARG_COUNT,
    PH_ARG_LEN,
    PH_PAYLOAD,
    PH_HALTED
  } parse_phase_t;

  // Kinds of malformed frame for the closing test
  typedef enum int unsigned {
    BAD_TOO_LONG,
    BAD_SHORT,
    BAD_TOO_MANY,
    BAD_ARG_OVERRUN,
    BAD_NO_ROOM,
    BAD_TRAILING_EMPTY,
    BAD_TRAILING_ARG
  } malformed_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rfd_in_if  in_if  ();
  rfd_out_if out_if ();

  request_frame_deframer_top #(
    .MAX_FRAME_BYTES (FRAME_CAP),
    .MAX_ARGS        (ARGS_CAP)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if),
    .out_m   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Model state: a copy of the limit registers and of the parser, both at
  // their reset values. Reset is applied only once, so no re-init is needed.
  // --------------------------------------------------------------------------
  logic [FRAME_LEN_W-1:0] lim_frame_reg = MAX_FRAME_LEN_RST;
  logic [ARG_CNT_W-1:0]   lim_args_reg  = MAX_ARG_CNT_RST;

  parse_phase_t           ph        = PH_FRAME_LEN;
  logic [31:0]            hdr_shift = '0;
  logic [1:0]             hdr_cnt   = '0;
  logic [FRAME_LEN_W-1:0] frm_len   = '0;
  logic [FRAME_LEN_W-1:0] frm_pos   = '0;
  logic [ARG_CNT_W-1:0]   args_left = '0;
  logic [31:0]            arg_left  = '0;
  logic [ARG_IDX_W-1:0]   cur_arg   = '0;
  logic                   halted    = 1'b0;

  res_t        deframed_q[$];   // results still owed by the block
  int unsigned arg_sizes[$];    // argument lengths of the next frame to send

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  int unsigned mismatches     = 0;
  int unsigned bytes_offered  = 0;
  int unsigned bytes_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned requests_done  = 0;
  int unsigned phases_run     = 0;
  err_t        final_err      = ERR_NONE;

  res_t        exp_res;
  res_t        new_res;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Deframing model
  // --------------------------------------------------------------------------
  function automatic int unsigned frame_limit();
    return (lim_frame_reg < FRAME_CAP) ? lim_frame_reg : FRAME_CAP;
  endfunction

  function automatic int unsigned arg_limit();
    return (lim_args_reg < ARGS_CAP) ? lim_args_reg : ARGS_CAP;
  endfunction

  function automatic res_t pack_result(kind_t k, logic [7:0] p, logic ae, logic re,
                                       err_t e);
    res_t x;
    x.kind        = k;
    x.payload     = p;
    x.arg_number  = cur_arg;
    x.arg_end     = ae;
    x.request_end = re;
    x.error_code  = e;
    return x;
  endfunction

  // Latches the error; nothing more comes out until reset
  function automatic res_t flag_error(err_t e);
    halted = 1'b1;
    ph     = PH_HALTED;
    return pack_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, e);
  endfunction

  // Little-endian header assembly; true once the fourth byte is in
  function automatic bit shift_header(logic [7:0] b);
    hdr_shift = {b, hdr_shift[31:8]};
    if (hdr_cnt == HDR_BYTES - 1) begin
      hdr_cnt = '0;
      return 1'b1;
    end
    hdr_cnt = hdr_cnt + 1'b1;
    return 1'b0;
  endfunction

  // End of an argument: may complete the request or swap in an error
  function automatic res_t close_arg(res_t r);
    args_left = args_left - 1'b1;
    if (args_left == 0) begin
      if (frm_pos == frm_len) begin
        r.request_end = 1'b1;
        ph            = PH_FRAME_LEN;
        return r;
      end
      return flag_error(ERR_TRAILING);
    end
    cur_arg = cur_arg + 1'b1;
    if (frm_len - frm_pos < HDR_BYTES) return flag_error(ERR_OVERRUN);
    ph = PH_ARG_LEN;
    return r;
  endfunction

  function automatic bit deframe_byte(logic [7:0] b, output res_t r);
    logic [31:0] v;
    logic [32:0] reach;
    r = '0;
    if (halted) return 1'b0;
    case (ph)
      PH_FRAME_LEN: begin
        if (!shift_header(b)) return 1'b0;
        v = hdr_shift;
        if (v > frame_limit()) begin
          r = flag_error(ERR_TOO_LONG);
          return 1'b1;
        end
        if (v < HDR_BYTES) begin
          r = flag_error(ERR_SHORT);
          return 1'b1;
        end
        frm_len = v[FRAME_LEN_W-1:0];
        frm_pos = '0;
        ph      = PH_ARG_COUNT;
        return 1'b0;
      end
      PH_ARG_COUNT: begin
        frm_pos = frm_pos + 1'b1;
        if (!shift_header(b)) return 1'b0;
        v       = hdr_shift;
        cur_arg = '0;
        if (v > arg_limit()) begin
          r = flag_error(ERR_TOO_MANY_ARGS);
          return 1'b1;
        end
        args_left = v[ARG_CNT_W-1:0];
        if (v == 0) begin
          if (frm_pos != frm_len) r = flag_error(ERR_TRAILING);
          else begin
            r  = pack_result(KIND_NO_ARGS, 8'h00, 1'b0, 1'b1, ERR_NONE);
            ph = PH_FRAME_LEN;
          end
          return 1'b1;
        end
        if (frm_len - frm_pos < HDR_BYTES) begin
          r = flag_error(ERR_OVERRUN);
          return 1'b1;
        end
        ph = PH_ARG_LEN;
        return 1'b0;
      end
      PH_ARG_LEN: begin
        frm_pos = frm_pos + 1'b1;
        if (!shift_header(b)) return 1'b0;
        v     = hdr_shift;
        reach = 33'(frm_pos) + 33'(v);
        if (reach > frm_len) begin
          r = flag_error(ERR_OVERRUN);
          return 1'b1;
        end
        if (v == 0) begin
          r = close_arg(pack_result(KIND_EMPTY_ARG, 8'h00, 1'b1, 1'b0, ERR_NONE));
          return 1'b1;
        end
        arg_left = v;
        ph       = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        frm_pos  = frm_pos + 1'b1;
        arg_left = arg_left - 1'b1;
        if (arg_left != 0) r = pack_result(KIND_PAYLOAD, b, 1'b0, 1'b0, ERR_NONE);
        else r = close_arg(pack_result(KIND_PAYLOAD, b, 1'b1, 1'b0, ERR_NONE));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled at the rising edge, so the values
  // seen are those in force at the edge. Results are checked before the
  // newly accepted byte is modelled; a byte never answers at its own edge.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (deframed_q.size() == 0) begin
        $error("result transaction with nothing expected: kind %0d", out_if.kind);
        mismatches++;
      end else begin
        exp_res = deframed_q.pop_front();
        check_field("kind",        10'(exp_res.kind),        10'(out_if.kind));
        check_field("payload",     10'(exp_res.payload),     10'(out_if.payload));
        check_field("arg_number",  exp_res.arg_number,       out_if.arg_number);
        check_field("arg_end",     10'(exp_res.arg_end),     10'(out_if.arg_end));
        check_field("request_end", 10'(exp_res.request_end), 10'(out_if.request_end));
        check_field("error_code",  10'(exp_res.error_code),  10'(out_if.error_code));
        if (exp_res.request_end) requests_done++;
        if (exp_res.kind == KIND_ERROR) final_err = exp_res.error_code;
      end
    end
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      bytes_taken++;
      if (deframe_byte(in_if.data_byte, new_res)) begin
        deframed_q.insert(deframed_q.size(), new_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls at the current rate, or a counted hold-off
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. valid is left high after a transaction, so back-to-back
  // bytes never lower and raise it in the same step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    bytes_offered++;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < HDR_BYTES; i++) send_byte(w[8*i +: 8]);
  endtask

  // Queues one argument length for the next frame
  function automatic void add_arg(input int unsigned len);
    arg_sizes.insert(arg_sizes.size(), len);
  endfunction

  // Well-formed frame from arg_sizes, random payload; clears arg_sizes
  task automatic send_frame();
    int unsigned body;
    body = HDR_BYTES;
    foreach (arg_sizes[i]) body += HDR_BYTES + arg_sizes[i];
    send_word(body);
    send_word(arg_sizes.size());
    foreach (arg_sizes[i]) begin
      send_word(arg_sizes[i]);
      repeat (arg_sizes[i]) send_byte(8'($urandom_range(255, 0)));
    end
    arg_sizes.delete();
  endtask

  // Random well-formed frame inside the current limits
  task automatic send_random_frame();
    int unsigned room;
    int unsigned n;
    int unsigned cap;
    int unsigned s;
    room = frame_limit() - HDR_BYTES;
    n    = (arg_limit() < MAX_RANDOM_ARGS) ? arg_limit() : MAX_RANDOM_ARGS;
    n    = $urandom_range(n, 0);
    for (int i = 0; i < n && room >= HDR_BYTES; i++) begin
      cap  = room - HDR_BYTES;
      if (cap > MAX_RANDOM_SIZE) cap = MAX_RANDOM_SIZE;
      s    = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(cap, 0);
      add_arg(s);
      room -= HDR_BYTES + s;
    end
    send_frame();
  endtask

  // Sender pauses until every result is in and the pipeline has emptied
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB register access; an idle bus state closes each access
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    if (idx == REG_MAX_FRAME_LEN) lim_frame_reg = val[FRAME_LEN_W-1:0];
    else lim_args_reg = val[ARG_CNT_W-1:0];
    apb_access(1'b0, idx, '0, rd);
    if (rd !== val) begin
      $error("%s readback: expected %0d, actual %0d", idx.name(), val, rd);
      mismatches++;
    end
  endtask

  // Limits change only with the block idle
  task automatic set_limits(input logic [FRAME_LEN_W-1:0] flen,
                            input logic [ARG_CNT_W-1:0] acnt);
    settle();
    write_reg(REG_MAX_FRAME_LEN, 32'(flen));
    write_reg(REG_MAX_ARG_COUNT, 32'(acnt));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limits: empty request, mixed empty/short args with extreme bytes
  task automatic test_directed();
    send_word(HDR_BYTES);
    send_word(0);
    // three args: empty, one byte 00, two bytes FF 5A
    send_word(19);
    send_word(3);
    send_word(0);
    send_word(1);
    send_byte(8'h00);
    send_word(2);
    send_byte(8'hFF);
    send_byte(8'h5A);
    add_arg(1);
    send_frame();
  endtask

  // Register extremes and frames that sit exactly on the limits
  task automatic test_limits();
    set_limits(13'd4, 11'd0);
    send_word(HDR_BYTES);
    send_word(0);
    // registers above the parameter caps: the caps apply
    set_limits(13'd8191, 11'd2047);
    repeat (8) add_arg(0);
    send_frame();
    set_limits(13'd60, 11'd4);
    add_arg(0);
    add_arg(10);
    add_arg(20);
    add_arg(10);
    send_frame();
    set_limits(MAX_FRAME_LEN_RST, MAX_ARG_CNT_RST);
  endtask

  // Long receiver hold-off while the sender keeps offering a long argument
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = LONG_HOLD;
    add_arg(40);
    send_frame();
    settle();
    add_arg(3);
    add_arg(0);
    add_arg(5);
    send_frame();
  endtask

  task automatic run_random_phase(input logic [FRAME_LEN_W-1:0] flen,
                                  input logic [ARG_CNT_W-1:0] acnt,
                                  input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned start;
    set_limits(flen, acnt);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = bytes_offered;
    while (bytes_offered - start < PHASE_BYTES) send_random_frame();
    phases_run++;
  endtask

  // Only well-formed frames here: any error would silence the block
  task automatic test_random();
    run_random_phase(MAX_FRAME_LEN_RST, MAX_ARG_CNT_RST, 0, 0);
    run_random_phase(13'd60, 11'd4, 54, 0);
    run_random_phase(13'd8191, 11'd2047, 0, 54);
    run_random_phase(FRAME_LEN_W'($urandom_range(FRAME_CAP, HDR_BYTES)),
                     ARG_CNT_W'($urandom_range(ARGS_CAP, 0)), 23, 23);
  endtask

  // One malformed frame of a random kind, then noise that must be ignored
  task automatic test_sticky_error();
    int unsigned flim;
    int unsigned alim;
    int unsigned s;
    int unsigned k;
    malformed_t  bad;
    set_limits(FRAME_LEN_W'($urandom_range(FRAME_CAP, 40)),
               ARG_CNT_W'($urandom_range(ARGS_CAP, 2)));
    flim = frame_limit();
    alim = arg_limit();
    s    = $urandom_range(6, 0);
    bad  = malformed_t'($urandom_range(BAD_TRAILING_ARG, BAD_TOO_LONG));
    case (bad)
      BAD_TOO_LONG: begin
        send_word($urandom_range(1, 0) ? flim + 1 : $urandom_range(32'hFFFF_FFFF, flim + 1));
      end
      BAD_SHORT: begin
        send_word($urandom_range(HDR_BYTES - 1, 0));
      end
      BAD_TOO_MANY: begin
        send_word(2 * HDR_BYTES);
        send_word($urandom_range(1, 0) ? alim + 1 : $urandom_range(32'hFFFF_FFFF, alim + 1));
      end
      BAD_ARG_OVERRUN: begin
        // the argument length alone runs past the body
        k = $urandom_range(20, 0);
        send_word(2 * HDR_BYTES + k);
        send_word(1);
        send_word($urandom_range(1, 0) ? k + 1 : $urandom_range(32'hFFFF_FFFF, k + 1));
      end
      BAD_NO_ROOM: begin
        // a second argument is due but under four bytes remain
        send_word(2 * HDR_BYTES + s + $urandom_range(HDR_BYTES - 1, 1));
        send_word(2);
        send_word(s);
      end
      BAD_TRAILING_EMPTY: begin
        send_word(HDR_BYTES + $urandom_range(10, 1));
        send_word(0);
      end
      default: begin
        // last argument ends short of the body end
        send_word(2 * HDR_BYTES + s + $urandom_range(8, 1));
        send_word(1);
        send_word(s);
      end
    endcase
    repeat (NOISE_BYTES) send_byte(8'($urandom_range(255, 0)));
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    test_sticky_error();
    settle();

    $display("Run covered %0d byte transactions in, %0d results checked, %0d requests",
             bytes_taken, results_seen, requests_done);
    $display("over %0d stall mixes and limit settings; closing error: %s",
             phases_run, final_err.name());
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### request_frame_deframer_top.f
sv/rfd_pkg.sv
sv/rfd_if.sv
sv/rfd_cfg.sv
sv/rfd_parse.sv
sv/request_frame_deframer_top.sv
tb/tb_request_frame_deframer_top.sv
